// File: rtl/core/dtmfev_pkg.sv
// Package for the DTMF telephone-event packet generator.
// Holds the payload and configuration types, command and register codes,
// and the key decode and saturation functions. No dependencies.
`default_nettype none

package dtmfev_pkg;

  localparam int END_PACKETS_DEF = 3;

  localparam int TS_W       = 32;
  localparam int SPF_W      = 11;
  localparam int INTERVAL_W = 12;
  localparam int PT_W       = 7;
  localparam int DUR_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SENDER_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_FRAME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_PAYLOAD_TYPE = 2'd2;

  localparam logic [SPF_W-1:0] SPF_RESET = 11'd80;
  localparam logic [PT_W-1:0]  PT_RESET  = 7'd101;
  localparam logic [5:0]       VOLUME_VAL = 6'd10;

  typedef struct packed {
    logic [1:0]      mode;
    logic [7:0]      tone_key;
    logic [TS_W-1:0] frame_timestamp;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       event_code;
    logic             end_flag;
    logic [5:0]       volume;
    logic [DUR_W-1:0] duration;
    logic             marker;
    logic [TS_W-1:0]  rtp_timestamp;
    logic [PT_W-1:0]  payload_type;
  } out_item_t;

  typedef struct packed {
    logic             sender_enable;
    logic [SPF_W-1:0] samples_per_frame;
    logic [PT_W-1:0]  event_payload_type;
  } cfg_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } key_map_t;

  // Accepts ASCII digits, raw digit values, '*', '#' and A-D in either case.
  function automatic key_map_t key_to_event(input logic [7:0] key);
    key_map_t m;
    m.hit  = 1'b1;
    m.code = 4'd0;
    if (key inside {[8'h30:8'h39]}) begin
      m.code = 4'(key - 8'h30);
    end else if (key inside {[8'd0:8'd9]}) begin
      m.code = key[3:0];
    end else if (key inside {[8'h41:8'h44]}) begin
      m.code = 4'(key - 8'h41 + 8'd12);
    end else if (key inside {[8'h61:8'h64]}) begin
      m.code = 4'(key - 8'h61 + 8'd12);
    end else if (key == 8'h2A) begin
      m.code = 4'd10;
    end else if (key == 8'h23) begin
      m.code = 4'd11;
    end else begin
      m.hit = 1'b0;
    end
    return m;
  endfunction

  function automatic logic [DUR_W-1:0] sat16(input logic [TS_W-1:0] v);
    return (|v[TS_W-1:DUR_W]) ? {DUR_W{1'b1}} : v[DUR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dtmf_event_packet_generator.sv
// Top level of the DTMF telephone-event packet generator: channel registers,
// configuration registers and the event engine. Depends on dtmfev_pkg and
// dtmfev_engine.
//
//   channel  direction  payload              handshake
//   in_      input      in_item_t            in_valid / in_ready
//   out_     output     out_item_t           out_valid / out_ready
//   cfg_     input      cfg_index, cfg_data  cfg_valid / cfg_ready
//
// One transaction per cycle is taken on the input unless the result register
// is full and not taken; a packet from a frame tick passes the input
// register, then the result register, before it is shown on out_valid.
// The rate is set by the single engine step between those two registers.
// When the result register is full and not taken, a transaction in the input
// register holds and in_ready drops. Synchronous active-low reset clears
// all event state; configuration writes are always accepted.
`default_nettype none

module dtmf_event_packet_generator #(
  parameter int END_PACKETS = dtmfev_pkg::END_PACKETS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire dtmfev_pkg::in_item_t                 in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output dtmfev_pkg::out_item_t                     out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [dtmfev_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dtmfev_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dtmfev_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  cfg_t      cfg_r;

  logic      advance;
  logic      res_valid;
  out_item_t res;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sender_enable      <= 1'b0;
      cfg_r.samples_per_frame  <= SPF_RESET;
      cfg_r.event_payload_type <= PT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SENDER_ENABLE:      cfg_r.sender_enable      <= cfg_data[0];
        CFG_SAMPLES_PER_FRAME:  cfg_r.samples_per_frame  <= cfg_data[SPF_W-1:0];
        CFG_EVENT_PAYLOAD_TYPE: cfg_r.event_payload_type <= cfg_data[PT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  dtmfev_engine #(
    .END_PACKETS (END_PACKETS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Transactions that make no packet still step the engine and leave the
  // result register empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dtmfev_engine.sv
// Event state and packet decision for the DTMF telephone-event generator.
// Takes one registered command or frame tick per step and builds the packet.
// Depends on dtmfev_pkg.
`default_nettype none

module dtmfev_engine #(
  parameter int END_PACKETS = dtmfev_pkg::END_PACKETS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  wire dtmfev_pkg::in_item_t item,
  input  wire dtmfev_pkg::cfg_t     cfg,
  output logic                      res_valid,
  output dtmfev_pkg::out_item_t     res
);
  import dtmfev_pkg::*;

  // Countdown holds -1 up to END_PACKETS.
  localparam int SW = $clog2(END_PACKETS + 1) + 1;
  localparam logic signed [SW-1:0] STOPS_IDLE = '1;
  localparam logic signed [SW-1:0] STOPS_FULL = SW'(END_PACKETS);

  logic                    tone_r, tone_nxt;
  logic [3:0]              event_r, event_nxt;
  logic                    pend_r, pend_nxt;
  logic signed [SW-1:0]    stops_r, stops_nxt;
  logic [TS_W-1:0]         start_r, start_nxt;
  logic [TS_W-1:0]         last_r, last_nxt;
  logic [INTERVAL_W-1:0]   interval_r, interval_nxt;
  logic [DUR_W-1:0]        total_r, total_nxt;

  key_map_t                km;
  logic                    stops_lt1;
  logic signed [SW-1:0]    stops_eff;
  logic signed [SW-1:0]    stops_dec;
  logic [TS_W-1:0]         start_eff;
  logic [TS_W-1:0]         prog_dur;
  logic [TS_W-1:0]         end_diff;
  logic [TS_W-1:0]         due_ts;
  logic                    due;
  logic [DUR_W-1:0]        total_eff;
  logic [TS_W-1:0]         ts;

  assign ts        = item.frame_timestamp;
  assign km        = key_to_event(item.tone_key);
  assign stops_lt1 = stops_r[SW-1] || (stops_r == '0);
  // A pending start resets the countdown and the start time before use.
  assign stops_eff = pend_r ? STOPS_IDLE : stops_r;
  assign start_eff = pend_r ? ts : start_r;
  assign stops_dec = stops_eff - SW'(1);
  assign prog_dur  = ts + TS_W'(cfg.samples_per_frame) - start_eff;
  assign end_diff  = ts - start_r;
  assign due_ts    = last_r + TS_W'(interval_r);
  assign due       = (due_ts <= ts);
  assign total_eff = (stops_eff == STOPS_FULL) ? sat16(end_diff) : total_r;

  always_comb begin
    tone_nxt     = tone_r;
    event_nxt    = event_r;
    pend_nxt     = pend_r;
    stops_nxt    = stops_r;
    start_nxt    = start_r;
    last_nxt     = last_r;
    interval_nxt = interval_r;
    total_nxt    = total_r;
    res_valid    = 1'b0;
    res.event_code    = event_r;
    res.end_flag      = 1'b0;
    res.volume        = VOLUME_VAL;
    res.duration      = sat16(prog_dur);
    res.marker        = pend_r;
    res.rtp_timestamp = start_eff;
    res.payload_type  = cfg.event_payload_type;

    if (step_en) begin
      case (item.mode)
        MODE_START: begin
          if (cfg.sender_enable && !tone_r && stops_lt1 && km.hit) begin
            tone_nxt  = 1'b1;
            event_nxt = km.code;
            pend_nxt  = 1'b1;
          end
        end
        MODE_STOP: begin
          if (tone_r && stops_lt1) begin
            stops_nxt = STOPS_FULL;
          end
        end
        MODE_TICK: begin
          if (tone_r && cfg.sender_enable) begin
            if (pend_r) begin
              start_nxt    = ts;
              interval_nxt = {cfg.samples_per_frame, 1'b0};
              stops_nxt    = STOPS_IDLE;
            end
            if (stops_eff[SW-1]) begin
              if (pend_r || due) begin
                res_valid = 1'b1;
                last_nxt  = ts;
                pend_nxt  = 1'b0;
              end
            end else begin
              res_valid    = 1'b1;
              res.end_flag = 1'b1;
              res.marker   = 1'b0;
              res.duration = total_eff;
              last_nxt     = ts;
              stops_nxt    = stops_dec;
              total_nxt    = total_eff;
              if (stops_dec[SW-1] || (stops_dec == '0)) begin
                tone_nxt  = 1'b0;
                stops_nxt = STOPS_IDLE;
                total_nxt = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r     <= 1'b0;
      event_r    <= '0;
      pend_r     <= 1'b0;
      stops_r    <= STOPS_IDLE;
      start_r    <= '0;
      last_r     <= '0;
      interval_r <= '0;
      total_r    <= '0;
    end else begin
      tone_r     <= tone_nxt;
      event_r    <= event_nxt;
      pend_r     <= pend_nxt;
      stops_r    <= stops_nxt;
      start_r    <= start_nxt;
      last_r     <= last_nxt;
      interval_r <= interval_nxt;
      total_r    <= total_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dtmfev_checker.sv
// Port-level checks for the DTMF telephone-event packet generator, bound to
// the top level. Depends on dtmfev_pkg.
`default_nettype none

module dtmfev_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire dtmfev_pkg::in_item_t              in_data,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire dtmfev_pkg::out_item_t             out_data
);
  import dtmfev_pkg::*;

  // A waiting input transaction must stay put until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transaction changed while waiting");

  // A stalled packet must stay put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  a_volume: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.volume == VOLUME_VAL)
    else $error("packet volume is not the fixed level");

  // End packets never carry the marker.
  a_end_no_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_flag |-> !out_data.marker)
    else $error("end packet with marker set");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("packet shown right after reset");

endmodule

bind dtmf_event_packet_generator dtmfev_checker u_dtmfev_checker (.*);

`default_nettype wire
